// ===== hw/rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared widths, codes and transfer types of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int CMD_W    = 2;
	localparam int BLK_W    = 14;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 15;

	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 15'd16384;

	localparam int MAX_BLOCKS_DEF = 16384;
	localparam int BPB_DEF        = 4096;
	localparam int WORD_BITS_DEF  = 32;

	// summary words: one bit per map word, one top bit per summary word
	localparam int SUM_W  = 32;
	localparam int SUM_LG = 5;

	// boot, super and root blocks, on top of the bitmap blocks
	localparam int RESERVED_LOW = 3;
	localparam int TINY_DISK    = 4;

	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FORMAT = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_SMALL = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [BLK_W-1:0] block_index;
	} req_t;

	typedef struct packed {
		logic [BLK_W-1:0]    allocated_block;
		logic [STATUS_W-1:0] status;
	} rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bba_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap block allocator
// Free map of disk blocks (1 = free) with allocate, free and format commands.
// ----------------------------------------------------------------------------
// Usage:
//  req (valid/stall) takes one command per transfer; rsp (valid/stall) returns
//  exactly one result per command, in order. cfg (valid/ready, always ready)
//  writes the disk size in blocks; write it only while no command is in flight.
//  The map sits in a word RAM, with a summary RAM of nonzero-word bits and a
//  register of nonzero-summary bits, so allocate reads one summary word and
//  one map word. Steps per command, from accept:
//    allocate: summary read, map read, write back, response register
//    free: both RAMs read together, then written back
//    full, out of range or unused command: straight to the response
//    format: count bitmap blocks, ceil(t / BITS_PER_BITMAP_BLOCK), then
//    sweep the map RAM write port over every map word, one word per cycle
//    (512 at default); a disk too small for the reserved blocks skips it.
//  The result sits in an output register; a stalled result holds it and
//  the block then waits with the next result before taking a new command.
//  Reset (arst_n) empties the map (nothing free) at once, with no clearing
//  pass, and sets the disk size to 16384.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
	import bba_pkg::*;
#(
	parameter int MAX_BLOCKS            = MAX_BLOCKS_DEF,
	parameter int BITS_PER_BITMAP_BLOCK = BPB_DEF,
	parameter int WORD_BITS             = WORD_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [TOTAL_W-1:0] cfg_data,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire req_t               req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output rsp_t                    rsp
);

	localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_LG   = $clog2(WORD_BITS);
	localparam int NGRP      = (MAP_WORDS + SUM_W - 1) / SUM_W;
	localparam int G_AW      = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int NGRP_P2   = 1 << G_AW;
	localparam int WF_W      = G_AW + SUM_LG;
	localparam int SLOTS     = NGRP_P2 * SUM_W;
	localparam int B_W       = WF_W + WORD_LG;
	localparam int A_0       = B_W + 1;
	localparam int A_1       = $clog2(BITS_PER_BITMAP_BLOCK + 1) + 1;
	localparam int A_2       = TOTAL_W + 1;
	localparam int A_01      = (A_0 > A_1) ? A_0 : A_1;
	localparam int A_W       = (A_01 > A_2) ? A_01 : A_2;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ALS  = 3'd1;
	localparam logic [2:0] S_ALM  = 3'd2;
	localparam logic [2:0] S_FRD  = 3'd3;
	localparam logic [2:0] S_FDIV = 3'd4;
	localparam logic [2:0] S_FSW  = 3'd5;
	localparam logic [2:0] S_RESP = 3'd6;

	logic [2:0]           state_q;
	logic [NGRP_P2-1:0]   top_q;
	logic [G_AW-1:0]      g_q;
	logic [SUM_LG-1:0]    j_q;
	logic [WORD_LG-1:0]   k_q;
	logic [SUM_W-1:0]     s_q;
	logic [A_W-1:0]       t_q;
	logic [A_W-1:0]       rem_q;
	logic [A_W-1:0]       n_q;
	logic [A_W-1:0]       lo_q;
	logic [WF_W-1:0]      wf_q;
	logic [SUM_W-1:0]     sacc_q;
	logic [TOTAL_W-1:0]   total_q;
	rsp_t                 res_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic                 m_we;
	logic [WF_W-1:0]      m_waddr;
	logic [WORD_BITS-1:0] m_wdata;
	logic [WF_W-1:0]      m_raddr;
	logic [WORD_BITS-1:0] m_rdata;
	logic                 s_we;
	logic [G_AW-1:0]      s_waddr;
	logic [SUM_W-1:0]     s_wdata;
	logic [G_AW-1:0]      s_raddr;
	logic [SUM_W-1:0]     s_rdata;

	logic                 accept;
	logic                 rsp_load;
	logic [A_W-1:0]       idx_a;
	logic                 idx_range;
	logic [WF_W-1:0]      req_word;
	logic [G_AW-1:0]      req_g;
	logic [SUM_LG-1:0]    req_j;
	logic [WORD_LG-1:0]   req_k;
	logic [G_AW-1:0]      top_lo;
	logic                 top_any;
	logic [SUM_LG-1:0]    s_lo;
	logic [WORD_LG-1:0]   m_lo;
	logic [A_W-1:0]       total_a;
	logic [A_W-1:0]       t_sat;
	logic [A_W-1:0]       bpb_a;
	logic [A_W-1:0]       lo_sum;
	logic                 too_small;
	logic [A_W-1:0]       wf_a;
	logic [A_W-1:0]       lo_w;
	logic [A_W-1:0]       t_w;
	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] hi_mask;
	logic [WORD_BITS-1:0] fmt_word;
	logic [SUM_W-1:0]     sacc_nx;
	logic                 grp_end;
	logic [SUM_W-1:0]     s_cur;
	logic [WORD_BITS-1:0] m_cur;
	logic [WORD_BITS-1:0] m_clr;
	logic [SUM_W-1:0]     s_clr;
	logic [A_W-1:0]       blk_a;

	bba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (SLOTS)
	) u_map_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	bba_ram #(
		.WIDTH (SUM_W),
		.DEPTH (NGRP_P2)
	) u_sum_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || !rsp_stall);

	assign idx_a     = A_W'(req.block_index);
	assign idx_range = (idx_a >= A_W'(MAX_BLOCKS));
	assign req_word  = idx_a[WORD_LG +: WF_W];
	assign req_g     = req_word[WF_W-1 -: G_AW];
	assign req_j     = req_word[SUM_LG-1:0];
	assign req_k     = idx_a[WORD_LG-1:0];

	always_comb begin
		top_lo = '0;
		for (int i = NGRP_P2 - 1; i >= 0; i--) begin
			if (top_q[i]) begin
				top_lo = G_AW'(i);
			end
		end
	end
	assign top_any = |top_q;

	always_comb begin
		s_lo = '0;
		for (int i = SUM_W - 1; i >= 0; i--) begin
			if (s_rdata[i]) begin
				s_lo = SUM_LG'(i);
			end
		end
	end

	always_comb begin
		m_lo = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (m_rdata[i]) begin
				m_lo = WORD_LG'(i);
			end
		end
	end

	assign total_a   = A_W'(total_q);
	assign t_sat     = (total_a > A_W'(MAX_BLOCKS)) ? A_W'(MAX_BLOCKS) : total_a;
	assign bpb_a     = A_W'(BITS_PER_BITMAP_BLOCK);
	assign lo_sum    = n_q + A_W'(RESERVED_LOW);
	assign too_small = (t_q <= A_W'(TINY_DISK)) || (t_q <= lo_sum);

	// format word: bits in [lo, t) of the word at wf_q
	assign wf_a  = A_W'(wf_q);
	assign lo_w  = lo_q >> WORD_LG;
	assign t_w   = t_q >> WORD_LG;

	always_comb begin
		if (wf_a > lo_w) begin
			lo_mask = '1;
		end else if (wf_a == lo_w) begin
			lo_mask = {WORD_BITS{1'b1}} << lo_q[WORD_LG-1:0];
		end else begin
			lo_mask = '0;
		end
		if (wf_a < t_w) begin
			hi_mask = '1;
		end else if (wf_a == t_w) begin
			hi_mask = ~({WORD_BITS{1'b1}} << t_q[WORD_LG-1:0]);
		end else begin
			hi_mask = '0;
		end
	end

	assign fmt_word = lo_mask & hi_mask;
	assign sacc_nx  = sacc_q | (SUM_W'(|fmt_word) << wf_q[SUM_LG-1:0]);
	assign grp_end  = &wf_q[SUM_LG-1:0];

	// entries not covered by a summary bit read as empty
	assign s_cur = top_q[g_q] ? s_rdata : '0;
	assign m_cur = s_cur[j_q] ? m_rdata : '0;

	assign m_clr = m_rdata & ~(WORD_BITS'(1) << m_lo);
	assign s_clr = s_q & ~(SUM_W'(1) << j_q);
	assign blk_a = A_W'({g_q, j_q, m_lo});

	always_comb begin
		m_we    = 1'b0;
		m_waddr = {g_q, j_q};
		m_wdata = m_clr;
		s_we    = 1'b0;
		s_waddr = g_q;
		s_wdata = s_clr;
		s_raddr = (req.cmd == CMD_ALLOC) ? top_lo : req_g;
		m_raddr = (state_q == S_ALS) ? {g_q, s_lo} : req_word;
		case (state_q)
			S_ALM: begin
				m_we = 1'b1;
				s_we = (m_clr == '0);
			end
			S_FRD: begin
				m_we    = 1'b1;
				m_wdata = m_cur | (WORD_BITS'(1) << k_q);
				s_we    = 1'b1;
				s_wdata = s_cur | (SUM_W'(1) << j_q);
			end
			S_FSW: begin
				m_we    = 1'b1;
				m_waddr = wf_q;
				m_wdata = fmt_word;
				s_we    = grp_end;
				s_waddr = wf_q[WF_W-1 -: G_AW];
				s_wdata = sacc_nx;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= '0;
			g_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			s_q         <= '0;
			t_q         <= '0;
			rem_q       <= '0;
			n_q         <= '0;
			lo_q        <= '0;
			wf_q        <= '0;
			sacc_q      <= '0;
			total_q     <= TOTAL_RESET;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				total_q <= cfg_data;
			end
			if (rsp_load) begin
				rsp_q       <= res_q;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.cmd)
							CMD_ALLOC: begin
								if (top_any) begin
									g_q     <= top_lo;
									state_q <= S_ALS;
								end else begin
									res_q   <= '{allocated_block: '0, status: STAT_FULL};
									state_q <= S_RESP;
								end
							end
							CMD_FREE: begin
								if (idx_range) begin
									res_q   <= '{allocated_block: '0, status: STAT_RANGE};
									state_q <= S_RESP;
								end else begin
									res_q   <= '{allocated_block: '0, status: STAT_OK};
									g_q     <= req_g;
									j_q     <= req_j;
									k_q     <= req_k;
									state_q <= S_FRD;
								end
							end
							CMD_FORMAT: begin
								res_q   <= '{allocated_block: '0, status: STAT_OK};
								t_q     <= t_sat;
								rem_q   <= t_sat;
								n_q     <= '0;
								state_q <= S_FDIV;
							end
							default: begin
								res_q   <= '{allocated_block: '0, status: STAT_OK};
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_ALS: begin
					j_q     <= s_lo;
					s_q     <= s_rdata;
					state_q <= S_ALM;
				end
				S_ALM: begin
					if ((m_clr == '0) && (s_clr == '0)) begin
						top_q[g_q] <= 1'b0;
					end
					res_q   <= '{allocated_block: blk_a[BLK_W-1:0], status: STAT_OK};
					state_q <= S_RESP;
				end
				S_FRD: begin
					top_q[g_q] <= 1'b1;
					state_q    <= S_RESP;
				end
				S_FDIV: begin
					if (rem_q == '0) begin
						if (too_small) begin
							res_q   <= '{allocated_block: '0, status: STAT_SMALL};
							state_q <= S_RESP;
						end else begin
							lo_q    <= lo_sum;
							wf_q    <= '0;
							sacc_q  <= '0;
							state_q <= S_FSW;
						end
					end else begin
						rem_q <= (rem_q > bpb_a) ? rem_q - bpb_a : '0;
						n_q   <= n_q + A_W'(1);
					end
				end
				S_FSW: begin
					if (grp_end) begin
						top_q[wf_q[WF_W-1 -: G_AW]] <= |sacc_nx;
						sacc_q                      <= '0;
					end else begin
						sacc_q <= sacc_nx;
					end
					wf_q <= wf_q + WF_W'(1);
					if (&wf_q) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_sum_word_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALM) |-> (s_q != '0))
		else $error("summary word flagged by top bit is empty");

	a_map_word_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALM) |-> (m_rdata != '0))
		else $error("map word flagged by summary bit is empty");

	a_full_zero_block: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status == STAT_FULL)) |-> (rsp.allocated_block == '0))
		else $error("full result carries a block number");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted command left the sequencer idle");
`endif

endmodule
`default_nettype wire
